// File: rtl/rv32d_pkg.sv
package rv32d_pkg;

   localparam int XLEN = 32;

   typedef enum logic [5:0] {
      MN_ILLEGAL = 6'd0,
      MN_LUI     = 6'd1,
      MN_AUIPC   = 6'd2,
      MN_JAL     = 6'd3,
      MN_JALR    = 6'd4,
      MN_BEQ     = 6'd5,
      MN_BNE     = 6'd6,
      MN_BLT     = 6'd7,
      MN_BGE     = 6'd8,
      MN_BLTU    = 6'd9,
      MN_BGEU    = 6'd10,
      MN_LB      = 6'd11,
      MN_LH      = 6'd12,
      MN_LW      = 6'd13,
      MN_LBU     = 6'd14,
      MN_LHU     = 6'd15,
      MN_SB      = 6'd16,
      MN_SH      = 6'd17,
      MN_SW      = 6'd18,
      MN_ADDI    = 6'd19,
      MN_SLTI    = 6'd20,
      MN_SLTIU   = 6'd21,
      MN_XORI    = 6'd22,
      MN_ORI     = 6'd23,
      MN_ANDI    = 6'd24,
      MN_SLLI    = 6'd25,
      MN_SRLI    = 6'd26,
      MN_SRAI    = 6'd27,
      MN_ADD     = 6'd28,
      MN_SUB     = 6'd29,
      MN_SLL     = 6'd30,
      MN_SLT     = 6'd31,
      MN_SLTU    = 6'd32,
      MN_XOR     = 6'd33,
      MN_SRL     = 6'd34,
      MN_SRA     = 6'd35,
      MN_OR      = 6'd36,
      MN_AND     = 6'd37,
      MN_ECALL   = 6'd38,
      MN_EBREAK  = 6'd39,
      MN_CSRRW   = 6'd40,
      MN_CSRRS   = 6'd41,
      MN_CSRRC   = 6'd42,
      MN_CSRRWI  = 6'd43,
      MN_CSRRSI  = 6'd44,
      MN_CSRRCI  = 6'd45
   } mnemonic_type;

   // major opcodes
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6f;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_ALUIMM = 7'h13;
   localparam logic [6:0] OP_ALU    = 7'h33;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   // funct3 codes
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   localparam logic [2:0] F3_SB = 3'd0;
   localparam logic [2:0] F3_SH = 3'd1;
   localparam logic [2:0] F3_SW = 3'd2;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_PRIV   = 3'd0;
   localparam logic [2:0] F3_CSRRW  = 3'd1;
   localparam logic [2:0] F3_CSRRS  = 3'd2;
   localparam logic [2:0] F3_CSRRC  = 3'd3;
   localparam logic [2:0] F3_CSRRWI = 3'd5;
   localparam logic [2:0] F3_CSRRSI = 3'd6;
   localparam logic [2:0] F3_CSRRCI = 3'd7;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [XLEN-1:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [XLEN-1:0] WORD_EBREAK = 32'h0010_0073;

   typedef struct packed {
      logic [XLEN-1:0] address;
      logic [XLEN-1:0] instruction;
   } req_word_type;

   typedef struct packed {
      mnemonic_type           mnemonic_code;
      logic [4:0]             dest_reg;
      logic [4:0]             src1_reg;
      logic [4:0]             src2_reg;
      logic signed [XLEN-1:0] immediate;
      logic [XLEN-1:0]        target;
      logic [11:0]            csr_number;
   } rsp_word_type;

endpackage

// File: rtl/rv32d_if.sv
interface rv32d_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] address;
   logic [31:0] instruction;

   modport source (output valid, output address, output instruction, input ready);
   modport sink (input valid, input address, input instruction, output ready);
endinterface

interface rv32d_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         mnemonic_code;
   logic [4:0]         dest_reg;
   logic [4:0]         src1_reg;
   logic [4:0]         src2_reg;
   logic signed [31:0] immediate;
   logic [31:0]        target;
   logic [11:0]        csr_number;

   modport source (output valid, output mnemonic_code, output dest_reg, output src1_reg,
                   output src2_reg, output immediate, output target, output csr_number,
                   input ready);
   modport sink (input valid, input mnemonic_code, input dest_reg, input src1_reg,
                 input src2_reg, input immediate, input target, input csr_number,
                 output ready);
endinterface

// File: rtl/rv32d_decode.sv
module rv32d_decode (
   input  rv32d_pkg::req_word_type word_in,
   output rv32d_pkg::rsp_word_type word_out
);
   import rv32d_pkg::*;

   logic [XLEN-1:0] w;
   logic [6:0]      op;
   logic [2:0]      f3;
   logic [6:0]      f7;
   logic [XLEN-1:0] imm_i;
   logic [XLEN-1:0] imm_s;
   logic [XLEN-1:0] imm_b;
   logic [XLEN-1:0] imm_j;
   logic [XLEN-1:0] imm_u;
   logic [XLEN-1:0] imm_shamt;
   logic [XLEN-1:0] imm;
   logic            use_target;
   mnemonic_type    code;
   rsp_word_type    dec;

   assign w  = word_in.instruction;
   assign op = w[6:0];
   assign f3 = w[14:12];
   assign f7 = w[31:25];

   assign imm_i     = {{20{w[31]}}, w[31:20]};
   assign imm_s     = {{20{w[31]}}, w[31:25], w[11:7]};
   assign imm_b     = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   assign imm_j     = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
   assign imm_u     = {12'd0, w[31:12]};
   assign imm_shamt = {27'd0, w[24:20]};

   always_comb begin
      code       = MN_ILLEGAL;
      imm        = '0;
      use_target = 1'b0;
      dec        = '0;
      case (op)
         OP_LUI, OP_AUIPC: begin
            code         = (op == OP_LUI) ? MN_LUI : MN_AUIPC;
            dec.dest_reg = w[11:7];
            imm          = imm_u;
         end
         OP_JAL: begin
            code         = MN_JAL;
            dec.dest_reg = w[11:7];
            imm          = imm_j;
            use_target   = 1'b1;
         end
         OP_JALR: begin
            code         = MN_JALR;
            dec.dest_reg = w[11:7];
            dec.src1_reg = w[19:15];
            imm          = imm_i;
         end
         OP_BRANCH: begin
            case (f3)
               F3_BEQ:  code = MN_BEQ;
               F3_BNE:  code = MN_BNE;
               F3_BLT:  code = MN_BLT;
               F3_BGE:  code = MN_BGE;
               F3_BLTU: code = MN_BLTU;
               F3_BGEU: code = MN_BGEU;
               default: code = MN_ILLEGAL;
            endcase
            dec.src1_reg = w[19:15];
            dec.src2_reg = w[24:20];
            imm          = imm_b;
            use_target   = 1'b1;
         end
         OP_LOAD: begin
            case (f3)
               F3_LB:   code = MN_LB;
               F3_LH:   code = MN_LH;
               F3_LW:   code = MN_LW;
               F3_LBU:  code = MN_LBU;
               F3_LHU:  code = MN_LHU;
               default: code = MN_ILLEGAL;
            endcase
            dec.dest_reg = w[11:7];
            dec.src1_reg = w[19:15];
            imm          = imm_i;
         end
         OP_STORE: begin
            case (f3)
               F3_SB:   code = MN_SB;
               F3_SH:   code = MN_SH;
               F3_SW:   code = MN_SW;
               default: code = MN_ILLEGAL;
            endcase
            dec.src1_reg = w[19:15];
            dec.src2_reg = w[24:20];
            imm          = imm_s;
         end
         OP_ALUIMM: begin
            case (f3)
               F3_ADD:  code = MN_ADDI;
               F3_SLL:  code = MN_SLLI;
               F3_SLT:  code = MN_SLTI;
               F3_SLTU: code = MN_SLTIU;
               F3_XOR:  code = MN_XORI;
               F3_SR: begin
                  if (f7 == F7_BASE)     code = MN_SRLI;
                  else if (f7 == F7_ALT) code = MN_SRAI;
                  else                   code = MN_ILLEGAL;
               end
               F3_OR:   code = MN_ORI;
               F3_AND:  code = MN_ANDI;
               default: code = MN_ILLEGAL;
            endcase
            dec.dest_reg = w[11:7];
            dec.src1_reg = w[19:15];
            imm          = (f3 == F3_SLL || f3 == F3_SR) ? imm_shamt : imm_i;
         end
         OP_ALU: begin
            case (f3)
               F3_ADD: begin
                  if (f7 == F7_BASE)     code = MN_ADD;
                  else if (f7 == F7_ALT) code = MN_SUB;
                  else                   code = MN_ILLEGAL;
               end
               F3_SLL:  code = MN_SLL;
               F3_SLT:  code = MN_SLT;
               F3_SLTU: code = MN_SLTU;
               F3_XOR:  code = MN_XOR;
               F3_SR: begin
                  if (f7 == F7_BASE)     code = MN_SRL;
                  else if (f7 == F7_ALT) code = MN_SRA;
                  else                   code = MN_ILLEGAL;
               end
               F3_OR:   code = MN_OR;
               F3_AND:  code = MN_AND;
               default: code = MN_ILLEGAL;
            endcase
            dec.dest_reg = w[11:7];
            dec.src1_reg = w[19:15];
            dec.src2_reg = w[24:20];
         end
         OP_SYSTEM: begin
            if (f3 == F3_PRIV) begin
               // only the two exact words are legal here
               if (w == WORD_ECALL)       code = MN_ECALL;
               else if (w == WORD_EBREAK) code = MN_EBREAK;
               else                       code = MN_ILLEGAL;
            end else begin
               case (f3)
                  F3_CSRRW:  code = MN_CSRRW;
                  F3_CSRRS:  code = MN_CSRRS;
                  F3_CSRRC:  code = MN_CSRRC;
                  F3_CSRRWI: code = MN_CSRRWI;
                  F3_CSRRSI: code = MN_CSRRSI;
                  F3_CSRRCI: code = MN_CSRRCI;
                  default:   code = MN_ILLEGAL;
               endcase
               dec.dest_reg   = w[11:7];
               dec.src1_reg   = w[19:15];
               dec.csr_number = w[31:20];
            end
         end
         default: code = MN_ILLEGAL;
      endcase

      dec.mnemonic_code = code;
      dec.immediate     = $signed(imm);
      dec.target        = use_target ? (word_in.address + imm) : '0;

      // an illegal word reports nothing but its code
      if (code == MN_ILLEGAL) begin
         dec = '0;
      end
   end

   assign word_out = dec;

endmodule

// File: rtl/rv32i_instruction_decoder.sv
// RV32I instruction decoder.
//
// req_port (sink): one word per instruction, carrying its byte address and
// the raw 32-bit instruction. rsp_port (source): one word per instruction
// with the mnemonic code (0 = illegal), rd/rs1/rs2, the immediate, the
// jal/branch target (address + immediate, wrapping) and the CSR number.
// Both channels use valid/ready; a word moves when both are high.
//
// One register holds the incoming word; the decode logic and target adder
// sit between it and the result register, which loads when it is empty or
// being drained. Throughput is 1 word per clock; words flow back to back
// as long as rsp_port.ready stays high.
//
// reset (synchronous, active high) empties both registers; nothing is
// pending afterwards. When the receiver stalls, the result register holds
// its word, the input register fills behind it, and only then does
// req_port.ready drop. Ready comes back the cycle the stall clears.
module rv32i_instruction_decoder (
   input logic        clock,
   input logic        reset,
   rv32d_req_if.sink   req_port,
   rv32d_rsp_if.source rsp_port
);
   import rv32d_pkg::*;

   // input register
   logic         in_valid_ff;
   logic         in_valid_in;
   req_word_type in_word_ff;

   // result register
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_word_type out_word_ff;

   rsp_word_type decoded;
   logic         out_load;
   logic         in_load;

   // result register takes a new word when it is empty or being drained
   assign out_load = !out_valid_ff || rsp_port.ready;
   // input register can take a word when it is empty or moving forward
   assign in_load  = !in_valid_ff || out_load;

   assign req_port.ready = in_load;

   assign in_valid_in  = in_load ? req_port.valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   rv32d_decode u_decode (
      .word_in  (in_word_ff),
      .word_out (decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (in_load && req_port.valid) begin
         in_word_ff.address     <= req_port.address;
         in_word_ff.instruction <= req_port.instruction;
      end
      if (out_load && in_valid_ff) begin
         out_word_ff <= decoded;
      end
   end

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.mnemonic_code = out_word_ff.mnemonic_code;
   assign rsp_port.dest_reg      = out_word_ff.dest_reg;
   assign rsp_port.src1_reg      = out_word_ff.src1_reg;
   assign rsp_port.src2_reg      = out_word_ff.src2_reg;
   assign rsp_port.immediate     = out_word_ff.immediate;
   assign rsp_port.target        = out_word_ff.target;
   assign rsp_port.csr_number    = out_word_ff.csr_number;

endmodule

// File: rtl/rv32d_checker.sv
module rv32d_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  mnemonic_code,
   input logic [4:0]  dest_reg,
   input logic [4:0]  src1_reg,
   input logic [4:0]  src2_reg,
   input logic [31:0] immediate,
   input logic [31:0] target,
   input logic [11:0] csr_number
);
   import rv32d_pkg::*;

   // nothing pending right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // stalled word stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // stalled word holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(mnemonic_code) && $stable(immediate)
         && $stable(target))
      else $error("rsp payload changed while stalled");

   // illegal words carry all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mnemonic_code == MN_ILLEGAL |->
         dest_reg == 5'd0 && src1_reg == 5'd0 && src2_reg == 5'd0 &&
         immediate == 32'd0 && target == 32'd0 && csr_number == 12'd0)
      else $error("illegal word with nonzero fields");

   // only jal and branches produce a target
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && target != 32'd0 |->
         mnemonic_code == MN_JAL || mnemonic_code == MN_BEQ ||
         mnemonic_code == MN_BNE || mnemonic_code == MN_BLT ||
         mnemonic_code == MN_BGE || mnemonic_code == MN_BLTU ||
         mnemonic_code == MN_BGEU)
      else $error("target set for a non-control-transfer word");

endmodule

bind rv32i_instruction_decoder rv32d_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .mnemonic_code (rsp_port.mnemonic_code),
   .dest_reg      (rsp_port.dest_reg),
   .src1_reg      (rsp_port.src1_reg),
   .src2_reg      (rsp_port.src2_reg),
   .immediate     (rsp_port.immediate),
   .target        (rsp_port.target),
   .csr_number    (rsp_port.csr_number)
);
